// ===== hdl/gmwm_pkg.sv =====
package gmwm_pkg;

    localparam int GRID_SIDE_DEF = 16;
    localparam int SENSOR_W      = 12;
    localparam int CFG_W         = 12;
    localparam int CFG_IDX_W     = 2;
    localparam int CMD_W         = 3;
    localparam int QRY_W         = 4;
    localparam int POS_W         = 4;

    localparam logic [CFG_W-1:0] LEFT_THR_RST  = 12'd2048;
    localparam logic [CFG_W-1:0] RIGHT_THR_RST = 12'd2048;
    localparam logic [CFG_W-1:0] MARGIN_RST    = 12'd10;

    typedef enum logic [CMD_W-1:0] {
        CMD_FWD         = 3'd0,
        CMD_TURN_L      = 3'd1,
        CMD_TURN_R      = 3'd2,
        CMD_SENSE_SIDES = 3'd3,
        CMD_SENSE_FRONT = 3'd4,
        CMD_READ        = 3'd5
    } t_cmd;

    // heading code doubles as the wall bit index in a cell word
    typedef enum logic [1:0] {
        HD_N = 2'd0,
        HD_S = 2'd1,
        HD_E = 2'd2,
        HD_W = 2'd3
    } t_heading;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_THR  = 2'd0,
        CFG_RIGHT_THR = 2'd1,
        CFG_MARGIN    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic             visited;
        logic [3:0]       walls;
    } t_cell;

    localparam int CELL_W = $bits(t_cell);

    typedef struct packed {
        logic [CFG_W-1:0] left_thr;
        logic [CFG_W-1:0] right_thr;
        logic [CFG_W-1:0] margin;
    } t_cfg;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [SENSOR_W-1:0] left_reading;
        logic [SENSOR_W-1:0] right_reading;
        logic [SENSOR_W-1:0] front_reading;
        logic [QRY_W-1:0]    query_x;
        logic [QRY_W-1:0]    query_y;
    } t_cmd_beat;

endpackage

// ===== hdl/gmwm_if.sv =====
interface gmwm_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [gmwm_pkg::CMD_W-1:0]    cmd;
    logic [gmwm_pkg::SENSOR_W-1:0] left_reading;
    logic [gmwm_pkg::SENSOR_W-1:0] right_reading;
    logic [gmwm_pkg::SENSOR_W-1:0] front_reading;
    logic [gmwm_pkg::QRY_W-1:0]    query_x;
    logic [gmwm_pkg::QRY_W-1:0]    query_y;

    modport source (
        output valid, cmd, left_reading, right_reading, front_reading, query_x, query_y,
        input  ready
    );
    modport sink (
        input  valid, cmd, left_reading, right_reading, front_reading, query_x, query_y,
        output ready
    );
endinterface

interface gmwm_res_if;
    logic                       valid;
    logic                       ready;
    logic [gmwm_pkg::POS_W-1:0] pos_x;
    logic [gmwm_pkg::POS_W-1:0] pos_y;
    logic [1:0]                 heading;
    logic                       wall_north;
    logic                       wall_south;
    logic                       wall_east;
    logic                       wall_west;
    logic                       cell_visited;

    modport source (
        output valid, pos_x, pos_y, heading, wall_north, wall_south, wall_east, wall_west,
               cell_visited,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, heading, wall_north, wall_south, wall_east, wall_west,
               cell_visited,
        output ready
    );
endinterface

// ===== hdl/gmwm_cfg_regs.sv =====
module gmwm_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [gmwm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gmwm_pkg::CFG_W-1:0]     i_cfg_wdata,
    output gmwm_pkg::t_cfg                 o_cfg
);

    gmwm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left_thr  <= gmwm_pkg::LEFT_THR_RST;
            r_cfg.right_thr <= gmwm_pkg::RIGHT_THR_RST;
            r_cfg.margin    <= gmwm_pkg::MARGIN_RST;
        end else if (i_cfg_we) begin
            case (gmwm_pkg::t_cfg_idx'(i_cfg_idx))
                gmwm_pkg::CFG_LEFT_THR:  r_cfg.left_thr  <= i_cfg_wdata;
                gmwm_pkg::CFG_RIGHT_THR: r_cfg.right_thr <= i_cfg_wdata;
                gmwm_pkg::CFG_MARGIN:    r_cfg.margin    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/gmwm_map_ram.sv =====
module gmwm_map_ram #(
    parameter int DEPTH = gmwm_pkg::GRID_SIDE_DEF * gmwm_pkg::GRID_SIDE_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_raddr,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  gmwm_pkg::t_cell i_wmask,
    input  gmwm_pkg::t_cell i_wdata,
    output gmwm_pkg::t_cell o_rdata
);

    gmwm_pkg::t_cell r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    gmwm_pkg::t_cell  r_q;
    logic             r_qv;
    gmwm_pkg::t_cell  eff_mask;
    gmwm_pkg::t_cell  eff_data;

    // an entry never written reads as zero, so its first write lays down the whole word
    assign eff_mask = r_vld[i_waddr] ? i_wmask : '1;
    assign eff_data = i_wdata & i_wmask;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            for (int b = 0; b < gmwm_pkg::CELL_W; b++) begin
                if (eff_mask[b]) begin
                    r_mem[i_waddr][b] <= eff_data[b];
                end
            end
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_qv  <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_qv <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_qv ? r_q : '0;

endmodule

// ===== hdl/gmwm_nav.sv =====
module gmwm_nav #(
    parameter int GRID_SIDE = gmwm_pkg::GRID_SIDE_DEF,
    parameter int CW        = $clog2(GRID_SIDE),
    parameter int AW        = $clog2(GRID_SIDE * GRID_SIDE)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  gmwm_pkg::t_cmd_beat i_beat,
    input  gmwm_pkg::t_cfg      i_cfg,
    output logic                o_we,
    output logic [AW-1:0]       o_waddr,
    output gmwm_pkg::t_cell     o_wmask,
    output gmwm_pkg::t_cell     o_wdata,
    output logic [AW-1:0]       o_raddr,
    output logic                o_in_grid,
    output logic [CW-1:0]       o_pos_x,
    output logic [CW-1:0]       o_pos_y,
    output gmwm_pkg::t_heading  o_heading
);

    localparam int QW = (CW > gmwm_pkg::QRY_W) ? CW + 1 : gmwm_pkg::QRY_W + 1;
    localparam logic [CW-1:0] EDGE = CW'(GRID_SIDE - 1);

    logic [CW-1:0]      r_x, r_y;
    gmwm_pkg::t_heading r_hd;
    logic [CW-1:0]      n_x, n_y;
    gmwm_pkg::t_heading n_hd;
    logic               wr;
    logic               left_seen, right_seen, front_seen;

    function automatic logic [AW-1:0] cell_idx(input logic [CW-1:0] x, input logic [CW-1:0] y);
        return AW'(AW'(y) * AW'(GRID_SIDE) + AW'(x));
    endfunction

    function automatic gmwm_pkg::t_heading left_of(input gmwm_pkg::t_heading h);
        case (h)
            gmwm_pkg::HD_N: return gmwm_pkg::HD_W;
            gmwm_pkg::HD_S: return gmwm_pkg::HD_E;
            gmwm_pkg::HD_E: return gmwm_pkg::HD_N;
            default:        return gmwm_pkg::HD_S;
        endcase
    endfunction

    function automatic gmwm_pkg::t_heading right_of(input gmwm_pkg::t_heading h);
        case (h)
            gmwm_pkg::HD_N: return gmwm_pkg::HD_E;
            gmwm_pkg::HD_S: return gmwm_pkg::HD_W;
            gmwm_pkg::HD_E: return gmwm_pkg::HD_S;
            default:        return gmwm_pkg::HD_N;
        endcase
    endfunction

    // reading > threshold - margin, rearranged to stay unsigned
    function automatic logic seen(input logic [gmwm_pkg::SENSOR_W-1:0] rd,
                                  input logic [gmwm_pkg::CFG_W-1:0] thr,
                                  input logic [gmwm_pkg::CFG_W-1:0] mrg);
        return ({1'b0, rd} + {1'b0, mrg}) > {1'b0, thr};
    endfunction

    assign left_seen  = seen(i_beat.left_reading, i_cfg.left_thr, i_cfg.margin);
    assign right_seen = seen(i_beat.right_reading, i_cfg.right_thr, i_cfg.margin);
    assign front_seen = seen(i_beat.front_reading, i_cfg.right_thr, i_cfg.margin);

    always_comb begin
        n_x       = r_x;
        n_y       = r_y;
        n_hd      = r_hd;
        wr        = 1'b0;
        o_wmask   = '0;
        o_wdata   = '0;
        o_in_grid = 1'b1;
        case (gmwm_pkg::t_cmd'(i_beat.cmd))
            gmwm_pkg::CMD_FWD: begin
                wr              = 1'b1;
                o_wmask.visited = 1'b1;
                o_wdata.visited = 1'b1;
                case (r_hd)
                    gmwm_pkg::HD_N: if (r_y != '0)   n_y = r_y - CW'(1);
                    gmwm_pkg::HD_S: if (r_y != EDGE) n_y = r_y + CW'(1);
                    gmwm_pkg::HD_E: if (r_x != EDGE) n_x = r_x + CW'(1);
                    default:        if (r_x != '0)   n_x = r_x - CW'(1);
                endcase
            end
            gmwm_pkg::CMD_TURN_L: n_hd = left_of(r_hd);
            gmwm_pkg::CMD_TURN_R: n_hd = right_of(r_hd);
            gmwm_pkg::CMD_SENSE_SIDES: begin
                wr                         = 1'b1;
                o_wmask.walls[left_of(r_hd)]  = 1'b1;
                o_wdata.walls[left_of(r_hd)]  = left_seen;
                o_wmask.walls[right_of(r_hd)] = 1'b1;
                o_wdata.walls[right_of(r_hd)] = right_seen;
            end
            gmwm_pkg::CMD_SENSE_FRONT: begin
                wr                  = 1'b1;
                o_wmask.walls[r_hd] = 1'b1;
                o_wdata.walls[r_hd] = front_seen;
            end
            gmwm_pkg::CMD_READ: begin
                o_in_grid = (QW'(i_beat.query_x) < QW'(GRID_SIDE))
                         && (QW'(i_beat.query_y) < QW'(GRID_SIDE));
            end
            default: ;
        endcase
    end

    assign o_we    = i_en & wr;
    assign o_waddr = cell_idx(r_x, r_y);
    assign o_raddr = (gmwm_pkg::t_cmd'(i_beat.cmd) == gmwm_pkg::CMD_READ)
                   ? cell_idx(CW'(i_beat.query_x), CW'(i_beat.query_y))
                   : cell_idx(n_x, n_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x  <= '0;
            r_y  <= EDGE;
            r_hd <= gmwm_pkg::HD_N;
        end else if (i_en) begin
            r_x  <= n_x;
            r_y  <= n_y;
            r_hd <= n_hd;
        end
    end

    assign o_pos_x   = n_x;
    assign o_pos_y   = n_y;
    assign o_heading = n_hd;

endmodule

// ===== hdl/grid_maze_wall_mapper.sv =====
// Dead-reckoning wall map for a robot on a square grid. Each command beat on i_cmd
// (forward, turn left, turn right, sense sides, sense front, read cell) yields exactly
// one result beat on o_res: the position and heading after the command, plus the four
// absolute wall bits and the visited mark of the current cell, or of the queried cell
// for read cell (zero when the query lies outside the grid). One beat is taken every
// clock while the sink keeps taking results; a command passes the input register that
// takes the beat, then the map access, then the output register, and the rate is set
// by the single read and single write port of the map memory, the read port used once
// and the write port at most once per command. The map is cleared at
// reset by a per-cell valid bit, so there is no clearing pass and commands are taken
// from the first cycle after reset. Thresholds and margin are written through the
// i_cfg_* port (0 left threshold, 1 right threshold, 2 margin) while no command is
// in flight; the front sensor is compared against the right threshold.
module grid_maze_wall_mapper #(
    parameter int GRID_SIDE = gmwm_pkg::GRID_SIDE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [gmwm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gmwm_pkg::CFG_W-1:0]     i_cfg_wdata,
    gmwm_cmd_if.sink                       i_cmd,
    gmwm_res_if.source                     o_res
);

    localparam int CW    = $clog2(GRID_SIDE);
    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);

    gmwm_pkg::t_cfg      cfg;

    // stage 1: registered command beat
    logic                r_s1_valid;
    gmwm_pkg::t_cmd_beat r_s1;

    // stage 2: state after the command, map read in flight, pending write for bypass
    logic                r_s2_valid;
    logic [CW-1:0]       r_s2_x, r_s2_y;
    gmwm_pkg::t_heading  r_s2_hd;
    logic                r_s2_in_grid;
    gmwm_pkg::t_cell     r_s2_fmask, r_s2_fdata;

    // stage 3: result register
    logic                r_o_valid;
    logic [gmwm_pkg::POS_W-1:0] r_o_x, r_o_y;
    gmwm_pkg::t_heading  r_o_hd;
    gmwm_pkg::t_cell     r_o_cell;

    logic                s1_ready, s2_ready, o_free;
    logic                adv2, adv3;

    logic                we, in_grid;
    logic [AW-1:0]       waddr, raddr;
    gmwm_pkg::t_cell     wmask, wdata, rdata, map_word;
    logic [CW-1:0]       nx, ny;
    gmwm_pkg::t_heading  nhd;

    // each stage loads when it is empty or its occupant moves on this cycle
    assign o_free   = !r_o_valid || o_res.ready;
    assign s2_ready = !r_s2_valid || o_free;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign adv2     = r_s1_valid && s2_ready;
    assign adv3     = r_s2_valid && o_free;

    assign i_cmd.ready = s1_ready;

    gmwm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    gmwm_nav #(
        .GRID_SIDE (GRID_SIDE),
        .CW        (CW),
        .AW        (AW)
    ) u_nav (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (adv2),
        .i_beat    (r_s1),
        .i_cfg     (cfg),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wmask   (wmask),
        .o_wdata   (wdata),
        .o_raddr   (raddr),
        .o_in_grid (in_grid),
        .o_pos_x   (nx),
        .o_pos_y   (ny),
        .o_heading (nhd)
    );

    gmwm_map_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (adv2),
        .i_raddr (raddr),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wmask (wmask),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    // stage 1: take a beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_cmd.valid) begin
            r_s1.cmd           <= i_cmd.cmd;
            r_s1.left_reading  <= i_cmd.left_reading;
            r_s1.right_reading <= i_cmd.right_reading;
            r_s1.front_reading <= i_cmd.front_reading;
            r_s1.query_x       <= i_cmd.query_x;
            r_s1.query_y       <= i_cmd.query_y;
        end
    end

    // stage 2: the memory read sees the array before this command's write,
    // so keep the write alongside and merge it when both hit the same cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_s2_x       <= nx;
            r_s2_y       <= ny;
            r_s2_hd      <= nhd;
            r_s2_in_grid <= in_grid;
            r_s2_fmask   <= (we && (waddr == raddr)) ? wmask : '0;
            r_s2_fdata   <= wdata;
        end
    end

    always_comb begin
        map_word = (rdata & ~r_s2_fmask) | (r_s2_fdata & r_s2_fmask);
        if (!r_s2_in_grid) begin
            map_word = '0;
        end
    end

    // stage 3: hold the result until the sink takes the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_free) begin
            r_o_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_o_x    <= gmwm_pkg::POS_W'(r_s2_x);
            r_o_y    <= gmwm_pkg::POS_W'(r_s2_y);
            r_o_hd   <= r_s2_hd;
            r_o_cell <= map_word;
        end
    end

    assign o_res.valid        = r_o_valid;
    assign o_res.pos_x        = r_o_x;
    assign o_res.pos_y        = r_o_y;
    assign o_res.heading      = r_o_hd;
    assign o_res.wall_north   = r_o_cell.walls[gmwm_pkg::HD_N];
    assign o_res.wall_south   = r_o_cell.walls[gmwm_pkg::HD_S];
    assign o_res.wall_east    = r_o_cell.walls[gmwm_pkg::HD_E];
    assign o_res.wall_west    = r_o_cell.walls[gmwm_pkg::HD_W];
    assign o_res.cell_visited = r_o_cell.visited;

endmodule
